>>> src/lie_pkg.sv
// shared types, codes and constants of the line input editor
// no dependencies; imported by every module of the block
package lie_pkg;

    // action codes of an input item
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_CHAR  = 2'd1;
    localparam logic [1:0] ACT_FAIL  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_ECHO  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    // character codes
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_KILL = 8'd21;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_BELL = 8'd7;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_INDEX = 2'd0;
    localparam logic [1:0] REG_MIN_CHAR  = 2'd1;
    localparam logic [1:0] REG_MAX_CHAR  = 2'd2;

    // configuration reset values
    localparam logic [7:0] RST_MAX_INDEX = 8'd255;
    localparam logic [7:0] RST_MIN_CHAR  = 8'd32;
    localparam logic [7:0] RST_MAX_CHAR  = 8'd126;

    // command codes passed from front to back
    localparam logic [2:0] OP_ABORT      = 3'd0;
    localparam logic [2:0] OP_ECHO       = 3'd1;
    localparam logic [2:0] OP_KILL       = 3'd2;
    localparam logic [2:0] OP_STORE_ECHO = 3'd3;
    localparam logic [2:0] OP_STORE_BELL = 3'd4;
    localparam logic [2:0] OP_RETURN     = 3'd5;

    // command queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] ch;
        logic [7:0] pos;
    } lie_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } lie_qstat_t;

endpackage

>>> src/line_input_editor.sv
// top level of the line input editor: front, command queue, back
// depends on lie_pkg, lie_front, lie_queue, lie_back
//
//  channel   direction  handshake            payload
//  s_*       in         s_valid / s_ready    action, char_code, vdu_pending
//  cfg_*     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  m_*       out        m_valid / m_ready    kind, position, byte_value, repeat_res, last
//
// an input transfer can be taken every cycle while the four-entry command queue has room
// each item gives zero to four results; the result channel moves one per cycle while m_ready is high,
// so the sustained item rate is set by the back end result expansion; the first result of an
// item passes through a queue slot, the current-command register and the output register
// reset: cursor zero, registers at defaults, queue and output empty
// a stalled result channel fills the queue, then drops s_ready; cfg_ready is always high
module line_input_editor import lie_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // input item channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_char_code,
    input  logic       s_vdu_pending,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_position,
    output logic [7:0] m_byte_value,
    output logic [7:0] m_repeat_res,
    output logic       m_last
);

    // queue handshake between the two halves
    lie_qstat_t q_stat;
    lie_cmd_t   push_cmd;
    lie_cmd_t   head_cmd;
    logic       q_push;
    logic       q_pop;

    // front: classify the item, update cursor, queue a command
    lie_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_char_code   (s_char_code),
        .s_vdu_pending (s_vdu_pending),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    // decoupling queue
    lie_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // back: one result per cycle into the output register while the result channel is not stalled
    lie_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_stat       (q_stat),
        .q_head       (head_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_position   (m_position),
        .m_byte_value (m_byte_value),
        .m_repeat_res (m_repeat_res),
        .m_last       (m_last)
    );

endmodule

>>> src/lie_front.sv
// front end: accepts input items and config writes, keeps the cursor,
// turns each item into at most one queued command; depends on lie_pkg
module lie_front import lie_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_char_code,
    input  logic       s_vdu_pending,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  lie_qstat_t q_stat,
    output logic       q_push,
    output lie_cmd_t   q_cmd
);

    logic [7:0] cursor_reg, cursor_next;
    logic [7:0] max_index_reg, min_char_reg, max_char_reg;
    logic       accept;
    logic       has_cmd;

    assign s_ready   = !q_stat.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign q_push    = accept && has_cmd;

    always_comb begin
        cursor_next = cursor_reg;
        has_cmd     = 1'b0;
        q_cmd.op    = OP_ECHO;
        q_cmd.ch    = s_char_code;
        q_cmd.pos   = cursor_reg;
        case (s_action)
            ACT_START: begin
                cursor_next = '0;
            end
            ACT_FAIL: begin
                has_cmd  = 1'b1;
                q_cmd.op = OP_ABORT;
            end
            ACT_CHAR: begin
                if (s_vdu_pending) begin
                    has_cmd  = 1'b1;
                    q_cmd.op = OP_ECHO;
                end else if (s_char_code == CH_DEL) begin
                    if (cursor_reg != '0) begin
                        has_cmd     = 1'b1;
                        q_cmd.op    = OP_ECHO;
                        cursor_next = cursor_reg - 8'd1;
                    end
                end else if (s_char_code == CH_KILL) begin
                    if (cursor_reg != '0) begin
                        has_cmd     = 1'b1;
                        q_cmd.op    = OP_KILL;
                        cursor_next = '0;
                    end
                end else if (s_char_code == CH_CR) begin
                    has_cmd  = 1'b1;
                    q_cmd.op = OP_RETURN;
                end else if (cursor_reg >= max_index_reg) begin
                    has_cmd  = 1'b1;
                    q_cmd.op = OP_STORE_BELL;
                end else begin
                    has_cmd  = 1'b1;
                    q_cmd.op = OP_STORE_ECHO;
                    if (s_char_code >= min_char_reg && s_char_code <= max_char_reg) begin
                        cursor_next = cursor_reg + 8'd1;
                    end
                end
            end
            default: begin
                // meaningless action: dropped
                has_cmd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
        end else if (accept) begin
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_index_reg <= RST_MAX_INDEX;
            min_char_reg  <= RST_MIN_CHAR;
            max_char_reg  <= RST_MAX_CHAR;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_MAX_INDEX: max_index_reg <= cfg_data;
                REG_MIN_CHAR:  min_char_reg  <= cfg_data;
                REG_MAX_CHAR:  max_char_reg  <= cfg_data;
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

endmodule

>>> src/lie_queue.sv
// short command queue between front and back
// register file with head and tail pointers; depends on lie_pkg
module lie_queue import lie_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  lie_cmd_t   push_cmd,
    input  logic       pop,
    output lie_cmd_t   head_cmd,
    output lie_qstat_t stat
);

    lie_cmd_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> src/lie_back.sv
// back end: expands queued commands into result items, one per cycle while the result channel is not stalled,
// through an output register; depends on lie_pkg
module lie_back import lie_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  lie_qstat_t q_stat,
    input  lie_cmd_t   q_head,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_position,
    output logic [7:0] m_byte_value,
    output logic [7:0] m_repeat_res,
    output logic       m_last
);

    lie_cmd_t   cur_reg;
    logic       cur_valid_reg;
    logic [1:0] step_reg;

    logic       m_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] position_reg, byte_reg, repeat_reg;
    logic       last_reg;

    logic [1:0] res_kind;
    logic [7:0] res_pos, res_byte, res_rep;
    logic       res_last;
    logic       advance, finishing;

    assign advance   = cur_valid_reg && (!m_valid_reg || m_ready);
    assign finishing = advance && res_last;
    assign q_pop     = !q_stat.empty && (!cur_valid_reg || finishing);

    // result for the current command and step
    always_comb begin
        res_kind = KIND_ECHO;
        res_pos  = '0;
        res_byte = '0;
        res_rep  = 8'd1;
        res_last = 1'b1;
        case (cur_reg.op)
            OP_ABORT: begin
                res_kind = KIND_ABORT;
                res_rep  = '0;
            end
            OP_ECHO: begin
                res_byte = cur_reg.ch;
            end
            OP_KILL: begin
                res_byte = CH_DEL;
                res_rep  = cur_reg.pos;
            end
            OP_STORE_ECHO, OP_STORE_BELL: begin
                if (step_reg == 2'd0) begin
                    res_kind = KIND_STORE;
                    res_pos  = cur_reg.pos;
                    res_byte = cur_reg.ch;
                    res_rep  = '0;
                    res_last = 1'b0;
                end else begin
                    res_byte = (cur_reg.op == OP_STORE_BELL) ? CH_BELL : cur_reg.ch;
                end
            end
            OP_RETURN: begin
                case (step_reg)
                    2'd0: begin
                        res_kind = KIND_STORE;
                        res_pos  = cur_reg.pos;
                        res_byte = CH_CR;
                        res_rep  = '0;
                        res_last = 1'b0;
                    end
                    2'd1: begin
                        res_byte = CH_CR;
                        res_last = 1'b0;
                    end
                    2'd2: begin
                        res_byte = CH_LF;
                        res_last = 1'b0;
                    end
                    default: begin
                        res_kind = KIND_DONE;
                        res_pos  = cur_reg.pos;
                        res_rep  = '0;
                    end
                endcase
            end
            default: begin
                res_kind = KIND_ABORT;
                res_rep  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
        end else if (q_pop) begin
            cur_valid_reg <= 1'b1;
            step_reg      <= '0;
        end else if (finishing) begin
            cur_valid_reg <= 1'b0;
        end else if (advance) begin
            step_reg <= step_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            kind_reg     <= res_kind;
            position_reg <= res_pos;
            byte_reg     <= res_byte;
            repeat_reg   <= res_rep;
            last_reg     <= res_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_position   = position_reg;
    assign m_byte_value = byte_reg;
    assign m_repeat_res = repeat_reg;
    assign m_last       = last_reg;

endmodule

>>> src/lie_checker.sv
// port-level checks on the result channel of the line input editor
// depends on lie_pkg; bound to line_input_editor below
module lie_checker import lie_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_position,
    input logic [7:0] m_byte_value,
    input logic [7:0] m_repeat_res,
    input logic       m_last
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_position)
            && $stable(m_byte_value) && $stable(m_repeat_res) && $stable(m_last))
        else $error("result changed while stalled");

    a_store: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_STORE |-> m_repeat_res == '0 && !m_last)
        else $error("store result malformed");

    a_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ECHO |-> m_repeat_res != '0 && m_position == '0)
        else $error("echo result malformed");

    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DONE |-> m_last && m_byte_value == '0)
        else $error("line complete result malformed");

    a_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ABORT |-> m_last && m_position == '0
            && m_byte_value == '0)
        else $error("abort result malformed");

endmodule

bind line_input_editor lie_checker u_lie_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_position   (m_position),
    .m_byte_value (m_byte_value),
    .m_repeat_res (m_repeat_res),
    .m_last       (m_last)
);

>>> bench/tb_line_input_editor.sv
// self-checking bench for line_input_editor: directed and random keystrokes
// under several register settings, with a scoreboard that predicts every result
// depends on lie_pkg and the line_input_editor rtl
module tb_line_input_editor;
    import lie_pkg::*;

    // selector with no meaning; the block drops it without a result
    localparam logic [1:0] ACT_NONE = 2'd3;
    // register index that maps to nothing
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int LONG_HOLD = 60;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 1000;

    // expected results and the editor state that produces them
    class editor_scoreboard;
        typedef struct {
            logic [1:0] kind;
            logic [7:0] position;
            logic [7:0] byte_value;
            logic [7:0] repeat_res;
            logic       last;
        } edit_result_t;

        logic [7:0] cursor;
        logic [7:0] max_index;
        logic [7:0] min_char;
        logic [7:0] max_char;
        edit_result_t expected_results[$];
        int errors;

        function new();
            cursor = 8'd0;
            max_index = RST_MAX_INDEX;
            min_char = RST_MIN_CHAR;
            max_char = RST_MAX_CHAR;
            errors = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void write_reg(logic [1:0] idx, logic [7:0] data);
            case (idx)
                REG_MAX_INDEX: max_index = data;
                REG_MIN_CHAR:  min_char = data;
                REG_MAX_CHAR:  max_char = data;
                default: ;
            endcase
        endfunction

        function void push(logic [1:0] kind, logic [7:0] pos, logic [7:0] val,
                           logic [7:0] rep);
            edit_result_t r;
            r.kind = kind;
            r.position = pos;
            r.byte_value = val;
            r.repeat_res = rep;
            r.last = 1'b0;
            expected_results.push_back(r);
        endfunction

        // one accepted keystroke event: update the cursor and queue its results
        function void note_item(logic [1:0] action, logic [7:0] ch, logic vdu);
            int first;
            first = expected_results.size();
            if (action == ACT_START) begin
                cursor = 8'd0;
            end else if (action == ACT_FAIL) begin
                push(KIND_ABORT, 8'd0, 8'd0, 8'd0);
            end else if (action == ACT_CHAR) begin
                if (vdu) begin
                    // display sequence bytes pass straight through
                    push(KIND_ECHO, 8'd0, ch, 8'd1);
                end else if (ch == CH_DEL) begin
                    if (cursor != 8'd0) begin
                        cursor = cursor - 8'd1;
                        push(KIND_ECHO, 8'd0, CH_DEL, 8'd1);
                    end
                end else if (ch == CH_KILL) begin
                    if (cursor != 8'd0) begin
                        push(KIND_ECHO, 8'd0, CH_DEL, cursor);
                        cursor = 8'd0;
                    end
                end else begin
                    push(KIND_STORE, cursor, ch, 8'd0);
                    if (ch == CH_CR) begin
                        push(KIND_ECHO, 8'd0, CH_CR, 8'd1);
                        push(KIND_ECHO, 8'd0, CH_LF, 8'd1);
                        push(KIND_DONE, cursor, 8'd0, 8'd0);
                    end else if (cursor >= max_index) begin
                        push(KIND_ECHO, 8'd0, CH_BELL, 8'd1);
                    end else begin
                        push(KIND_ECHO, 8'd0, ch, 8'd1);
                        if (ch >= min_char && ch <= max_char)
                            cursor = cursor + 8'd1;
                    end
                end
            end
            if (expected_results.size() > first)
                expected_results[expected_results.size() - 1].last = 1'b1;
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [1:0] kind, logic [7:0] pos, logic [7:0] val,
                          logic [7:0] rep, logic last);
            edit_result_t e;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d", kind));
            end else begin
                e = expected_results.pop_front();
                if (kind !== e.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
                if (pos !== e.position)
                    report_mismatch($sformatf("position %0d, want %0d", pos, e.position));
                if (val !== e.byte_value)
                    report_mismatch($sformatf("byte_value %0d, want %0d", val,
                                              e.byte_value));
                if (rep !== e.repeat_res)
                    report_mismatch($sformatf("repeat_res %0d, want %0d", rep,
                                              e.repeat_res));
                if (last !== e.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, e.last));
            end
        endtask
    endclass

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_action;
    logic [7:0] s_char_code;
    logic       s_vdu_pending;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       m_valid;
    logic       m_ready;
    logic [1:0] m_kind;
    logic [7:0] m_position;
    logic [7:0] m_byte_value;
    logic [7:0] m_repeat_res;
    logic       m_last;

    editor_scoreboard sb;
    bit idle_on;        // random gaps on both sides
    bit long_hold_req;  // asks the receiver for one long hold-off
    int quiet_cycles;

    line_input_editor dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_char_code   (s_char_code),
        .s_vdu_pending (s_vdu_pending),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_position    (m_position),
        .m_byte_value  (m_byte_value),
        .m_repeat_res  (m_repeat_res),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // monitors: every transfer is seen at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_valid && s_ready)
                sb.note_item(s_action, s_char_code, s_vdu_pending);
            if (m_valid && m_ready)
                sb.check_result(m_kind, m_position, m_byte_value, m_repeat_res, m_last);
        end
    end

    // watchdog: a run with no transfer for too long has hung
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL line_input_editor");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // one input transfer; called and returns at a falling edge
    task automatic send_item(logic [1:0] action, logic [7:0] ch, logic vdu);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= action;
        s_char_code <= ch;
        s_vdu_pending <= vdu;
        forever begin
            @(posedge aclk);
            if (s_ready)
                break;
        end
        @(negedge aclk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(logic [1:0] idx, logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever begin
            @(posedge aclk);
            if (cfg_ready)
                break;
        end
        @(negedge aclk);
    endtask

    // wait for every expected result, then let start items still in flight settle
    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // mostly ordinary typing with edits and returns, some noise
    task automatic send_random(output bit counted);
        int r;
        logic [1:0] action;
        logic [7:0] ch;
        logic vdu;
        r = $urandom_range(0, 99);
        action = ACT_CHAR;
        vdu = 1'b0;
        ch = 8'($urandom_range(32, 126));
        if (r < 5) begin
            action = ACT_START;
            ch = 8'($urandom_range(0, 255));
            vdu = 1'($urandom_range(0, 1));
        end else if (r < 9) begin
            action = ACT_FAIL;
            ch = 8'($urandom_range(0, 255));
            vdu = 1'($urandom_range(0, 1));
        end else if (r < 12) begin
            action = ACT_NONE;
            ch = 8'($urandom_range(0, 255));
            vdu = 1'($urandom_range(0, 1));
        end else if (r < 20) begin
            vdu = 1'b1;
            ch = 8'($urandom_range(0, 255));
        end else if (r < 28) begin
            ch = CH_DEL;
        end else if (r < 32) begin
            ch = CH_KILL;
        end else if (r < 37) begin
            ch = CH_CR;
        end else if (r < 52) begin
            ch = 8'($urandom_range(0, 255));
        end
        send_item(action, ch, vdu);
        counted = (action != ACT_NONE);
    endtask

    // register settings per random phase, extremes included
    logic [7:0] phase_max_index [PHASES] = '{8'd0, 8'd3, 8'd255, 8'd1, 8'd10, 8'd255};
    logic [7:0] phase_min_char [PHASES]  = '{8'd0, 8'd48, 8'd255, 8'd0, 8'd65, 8'd32};
    logic [7:0] phase_max_char [PHASES]  = '{8'd255, 8'd57, 8'd0, 8'd0, 8'd90, 8'd126};

    initial begin
        int sent;
        bit counted;
        sb = new();
        idle_on = 1'b1;
        long_hold_req = 1'b0;
        quiet_cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_action = ACT_START;
        s_char_code = 8'd0;
        s_vdu_pending = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_INDEX;
        cfg_data = 8'd0;
        m_ready = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part at the reset register values
        send_item(ACT_START, 8'hFF, 1'b1);      // start with junk in the unused fields
        send_item(ACT_CHAR, CH_DEL, 1'b0);      // delete with an empty line
        send_item(ACT_CHAR, CH_KILL, 1'b0);     // kill with an empty line
        send_item(ACT_CHAR, 8'd65, 1'b0);
        send_item(ACT_CHAR, 8'd255, 1'b0);      // stored and echoed, cursor holds
        send_item(ACT_CHAR, 8'd0, 1'b0);
        send_item(ACT_CHAR, 8'd31, 1'b0);       // just below the printable range
        send_item(ACT_CHAR, 8'd32, 1'b0);       // range edges advance
        send_item(ACT_CHAR, 8'd126, 1'b0);
        send_item(ACT_CHAR, CH_DEL, 1'b1);      // display bytes are only echoed
        send_item(ACT_CHAR, CH_KILL, 1'b1);
        send_item(ACT_CHAR, 8'd0, 1'b1);
        send_item(ACT_CHAR, CH_DEL, 1'b0);      // back up one
        send_item(ACT_CHAR, CH_KILL, 1'b0);     // erase the rest of the line
        send_item(ACT_FAIL, 8'd0, 1'b0);
        send_item(ACT_FAIL, 8'hFF, 1'b1);
        send_item(ACT_NONE, 8'hAA, 1'b1);       // meaningless selector is dropped
        send_item(ACT_CHAR, CH_CR, 1'b0);       // return on an empty line
        send_item(ACT_START, 8'd0, 1'b0);
        send_item(ACT_CHAR, 8'd72, 1'b0);
        send_item(ACT_CHAR, 8'd105, 1'b0);
        send_item(ACT_CHAR, CH_CR, 1'b0);       // return after two characters
        send_item(ACT_CHAR, CH_LF, 1'b0);       // line feed is an ordinary store

        // random phases; the cursor carries across so a lowered limit can sit below it
        for (int p = 0; p < PHASES; p++) begin
            s_valid <= 1'b0;
            wait_drained();
            write_reg(REG_MAX_INDEX, phase_max_index[p]);
            write_reg(REG_MIN_CHAR, phase_min_char[p]);
            write_reg(REG_MAX_CHAR, phase_max_char[p]);
            write_reg(REG_UNUSED, 8'($urandom_range(0, 255)));   // ignored by the block
            cfg_valid <= 1'b0;
            // no idling in the last part of the run
            idle_on = (p != PHASES - 1);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                // receiver holds off while input keeps coming, filling the queue
                if (p == 2 && sent == 4)
                    long_hold_req = 1'b1;
                // sender waits out every pending result once mid-phase
                if (p == 3 && sent == 10) begin
                    s_valid <= 1'b0;
                    while (sb.pending() != 0)
                        @(posedge aclk);
                    @(negedge aclk);
                end
                send_random(counted);
                if (counted)
                    sent++;
            end
        end

        s_valid <= 1'b0;
        wait_drained();
        if (sb.errors == 0) begin
            $display("PASS line_input_editor");
        end else begin
            $display("FAIL line_input_editor");
        end
        $finish;
    end

endmodule
